/* hw/rtl/ddrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited decimal record parser package
// Shared constants, byte codes and the classified-operation type that the
// front end hands to the back end through the operation queue.
// ----------------------------------------------------------------------------
package ddrp_pkg;

  // Record layout.
  localparam int NUM_FIELDS  = 5;
  localparam int FIELD_W     = 16;
  localparam int CNT_W       = $clog2(NUM_FIELDS + 1);
  localparam int STORE_IDX_W = $clog2(NUM_FIELDS);

  // The magnitude accumulator saturates at 2^(FIELD_W-1)+1.
  localparam int ACC_W = FIELD_W + 1;
  localparam int MUL_W = ACC_W + 4;

  // Operation queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_SPACE,
    OP_MINUS,
    OP_PLUS,
    OP_AMP,
    OP_SEMI,
    OP_OTHER
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [3:0] digit;
  } ddrp_op_t;

endpackage

/* hw/rtl/ddrp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser front end
// Accepts input bytes, classifies them and holds the classified operation
// in a register until the operation queue takes it.
// ----------------------------------------------------------------------------
module ddrp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        byte_in_i,
  output logic              op_valid_o,
  input  logic              op_stall_i,
  output ddrp_pkg::ddrp_op_t op_o
);
  import ddrp_pkg::*;

  logic     valid_q;
  ddrp_op_t op_q;
  ddrp_op_t op_d;
  logic     accept;
  logic     load;

  // A held operation blocks new bytes only while the queue refuses it.
  assign in_stall_o = valid_q & op_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign load       = accept;

  always_comb begin
    op_d.digit = byte_in_i[3:0];
    unique case (byte_in_i) inside
      [CH_ZERO:CH_NINE]:    op_d.kind = OP_DIGIT;
      [CH_TAB:CH_CR],
      CH_SPACE:             op_d.kind = OP_SPACE;
      CH_MINUS:             op_d.kind = OP_MINUS;
      CH_PLUS:              op_d.kind = OP_PLUS;
      CH_AMP:               op_d.kind = OP_AMP;
      CH_SEMI:              op_d.kind = OP_SEMI;
      default:              op_d.kind = OP_OTHER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

/* hw/rtl/ddrp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation queue
// Short first-in first-out buffer of classified operations that decouples
// the front end from the back end.
// ----------------------------------------------------------------------------
module ddrp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  ddrp_pkg::ddrp_op_t push_op_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output ddrp_pkg::ddrp_op_t pop_op_o
);
  import ddrp_pkg::*;

  ddrp_op_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                push;
  logic                pop;

  localparam logic [QCNT_W-1:0] DEPTH_C = QCNT_W'(QUEUE_DEPTH);
  localparam logic [QPTR_W-1:0] LAST_C  = QPTR_W'(QUEUE_DEPTH - 1);

  assign push_stall_o = (count_q == DEPTH_C);
  assign push         = push_valid_i & ~push_stall_o;
  assign pop_valid_o  = (count_q != '0);
  assign pop          = pop_i & pop_valid_o;
  assign pop_op_o     = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

/* hw/rtl/ddrp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser back end
// Executes classified operations: decimal accumulation, field closing with
// saturation, and the record result register.
// ----------------------------------------------------------------------------
module ddrp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              op_valid_i,
  output logic                              op_pop_o,
  input  ddrp_pkg::ddrp_op_t                op_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ddrp_pkg::FIELD_W-1:0]      res_field_o [ddrp_pkg::NUM_FIELDS],
  output logic [ddrp_pkg::CNT_W-1:0]        res_count_o,
  output logic                              res_extra_o,
  output logic                              res_clip_o
);
  import ddrp_pkg::*;

  // Number phase codes.
  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [ACC_W-1:0] HALF_C    = ACC_W'(1) << (FIELD_W - 1);
  localparam logic [ACC_W-1:0] ACC_MAX_C = HALF_C + ACC_W'(1);
  localparam logic [CNT_W-1:0] NUM_C     = CNT_W'(NUM_FIELDS);

  logic [ACC_W-1:0]   acc_q,   acc_d;
  logic               neg_q,   neg_d;
  logic [1:0]         phase_q, phase_d;
  logic [CNT_W-1:0]   idx_q,   idx_d;
  logic               extra_q, extra_d;
  logic               clip_q,  clip_d;
  logic [FIELD_W-1:0] store_q [NUM_FIELDS];
  logic [FIELD_W-1:0] store_d [NUM_FIELDS];

  logic               res_valid_q;
  logic [FIELD_W-1:0] res_field_q [NUM_FIELDS];
  logic [CNT_W-1:0]   res_count_q;
  logic               res_extra_q;
  logic               res_clip_q;

  logic               out_take;
  logic               res_load;
  logic [MUL_W-1:0]   mul_sum;
  logic [ACC_W-1:0]   acc_next;
  logic               field_clip;
  logic [ACC_W-1:0]   field_mag;
  logic [FIELD_W-1:0] field_val;

  assign out_take = res_valid_q & ~out_stall_i;

  // A record end needs the result register; everything else always proceeds.
  assign op_pop_o = op_valid_i &
                    ((op_i.kind != OP_SEMI) | ~res_valid_q | ~out_stall_i);

  // acc * 10 + digit, saturated.
  assign mul_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + MUL_W'(op_i.digit);
  assign acc_next = (mul_sum > MUL_W'(ACC_MAX_C)) ? ACC_MAX_C : mul_sum[ACC_W-1:0];

  always_comb begin
    if (neg_q) begin
      field_clip = (acc_q > HALF_C);
      field_mag  = field_clip ? HALF_C : acc_q;
      field_val  = ~field_mag[FIELD_W-1:0] + FIELD_W'(1);
    end else begin
      field_clip = (acc_q >= HALF_C);
      field_mag  = field_clip ? (HALF_C - ACC_W'(1)) : acc_q;
      field_val  = field_mag[FIELD_W-1:0];
    end
  end

  always_comb begin
    acc_d    = acc_q;
    neg_d    = neg_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    extra_d  = extra_q;
    clip_d   = clip_q;
    store_d  = store_q;
    res_load = 1'b0;
    if (op_pop_o) begin
      unique case (op_i.kind)
        OP_SEMI: begin
          res_load = 1'b1;
          acc_d    = '0;
          neg_d    = 1'b0;
          phase_d  = PH_LEAD;
          idx_d    = '0;
          extra_d  = 1'b0;
          clip_d   = 1'b0;
          for (int i = 0; i < NUM_FIELDS; i++) begin
            store_d[i] = '0;
          end
        end
        OP_AMP: begin
          if (idx_q >= NUM_C) begin
            extra_d = 1'b1;
          end else begin
            store_d[idx_q[STORE_IDX_W-1:0]] = field_val;
            idx_d  = idx_q + CNT_W'(1);
            clip_d = clip_q | field_clip;
          end
          acc_d   = '0;
          neg_d   = 1'b0;
          phase_d = PH_LEAD;
        end
        OP_DIGIT: begin
          if (phase_q != PH_DONE) begin
            acc_d   = acc_next;
            phase_d = PH_DIGITS;
          end
        end
        OP_SPACE: begin
          if (phase_q != PH_LEAD) begin
            phase_d = PH_DONE;
          end
        end
        OP_MINUS: begin
          if (phase_q == PH_LEAD) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN;
          end else begin
            phase_d = PH_DONE;
          end
        end
        OP_PLUS: begin
          phase_d = (phase_q == PH_LEAD) ? PH_SIGN : PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      neg_q       <= 1'b0;
      phase_q     <= PH_LEAD;
      idx_q       <= '0;
      extra_q     <= 1'b0;
      clip_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      extra_q <= extra_d;
      clip_q  <= clip_d;
      store_q <= store_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_take) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_field_q <= store_q;
      res_count_q <= idx_q;
      res_extra_q <= extra_q;
      res_clip_q  <= clip_q;
    end
  end

  assign out_valid_o = res_valid_q;
  assign res_field_o = res_field_q;
  assign res_count_o = res_count_q;
  assign res_extra_o = res_extra_q;
  assign res_clip_o  = res_clip_q;

  // The captured-field count never passes the number of field slots.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= NUM_C)
    else $error("field count out of range");

  // Dropped fields are only possible once every slot is filled.
  a_extra_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    extra_q |-> (idx_q == NUM_C))
    else $error("extra flag set with free slots");

  // The accumulator stays within its saturation cap.
  a_acc_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ACC_MAX_C)
    else $error("accumulator above cap");

  // A record end is never executed over a pending, stalled result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_pop_o && op_i.kind == OP_SEMI) |-> !(res_valid_q && out_stall_i))
    else $error("result overwritten");

  // After a record end the per-record state is cleared.
  a_record_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_pop_o && op_i.kind == OP_SEMI) |=>
      (idx_q == '0 && !extra_q && !clip_q && res_valid_q))
    else $error("record state not cleared");

endmodule

/* hw/rtl/delimited_decimal_record_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited decimal record parser
// Parses ASCII records of '&'-terminated decimal fields ended by ';' and
// returns up to five saturated 16-bit values with a count and status flags.
// ----------------------------------------------------------------------------
// A ';' accepted at the input passes through the front register, the queue
// entry and the result register, in that order, before it appears as a result
// transaction. Throughput: one byte per cycle with no bubbles while the output
// is not stalled; a stalled result holds back the next ';' and, once the queue
// fills, all further input. Reset clears all control state and the field
// store; the block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module delimited_decimal_record_parser (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           byte_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ddrp_pkg::FIELD_W-1:0]  lock_value_o,
  output logic signed [ddrp_pkg::FIELD_W-1:0]  throttle_o,
  output logic signed [ddrp_pkg::FIELD_W-1:0]  gyro_x_o,
  output logic signed [ddrp_pkg::FIELD_W-1:0]  gyro_y_o,
  output logic signed [ddrp_pkg::FIELD_W-1:0]  gyro_z_o,
  output logic [ddrp_pkg::CNT_W-1:0]           fields_found_o,
  output logic                                 extra_fields_o,
  output logic                                 clipped_o
);
  import ddrp_pkg::*;

  // Front end to queue.
  logic     f_valid;
  logic     f_stall;
  ddrp_op_t f_op;

  // Queue to back end.
  logic     q_valid;
  logic     q_pop;
  ddrp_op_t q_op;

  logic [FIELD_W-1:0] res_field [NUM_FIELDS];

  // The front end classifies each byte (digit, white space, sign, field
  // end, record end or anything else) so the back end only sees a small
  // operation code and a digit value.
  ddrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .op_valid_o (f_valid),
    .op_stall_i (f_stall),
    .op_o       (f_op)
  );

  // The queue lets the front keep taking bytes while the back end waits
  // on a stalled result transaction.
  ddrp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_stall_o (f_stall),
    .push_op_i    (f_op),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_op_o     (q_op)
  );

  // The back end runs the number parser: a multiply-by-ten accumulate per
  // digit, saturation on field close, and the record result register.
  ddrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_pop_o    (q_pop),
    .op_i        (q_op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_field_o (res_field),
    .res_count_o (fields_found_o),
    .res_extra_o (extra_fields_o),
    .res_clip_o  (clipped_o)
  );

  // Fields map to the named outputs in arrival order.
  assign lock_value_o = $signed(res_field[0]);
  assign throttle_o   = $signed(res_field[1]);
  assign gyro_x_o     = $signed(res_field[2]);
  assign gyro_y_o     = $signed(res_field[3]);
  assign gyro_z_o     = $signed(res_field[4]);

endmodule
